[src/rgbre_pkg.sv]
package rgbre_pkg;

    // Default pixel count
    localparam int NUM_PIXELS_DEF = 3;

    // Register reset values
    localparam logic [15:0] INTERVAL_RST = 16'd30;
    localparam logic [7:0]  STEP_RST     = 8'd20;

    // Color limits and channel numbering (0 red, 1 green, 2 blue)
    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [1:0] CHAN_LAST = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;

    typedef enum logic [1:0] {
        ACT_SET     = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_BLINK   = 2'd2,
        ACT_RAINBOW = 2'd3
    } action_t;

    typedef logic [7:0] level_t;

    // Index 0 is red, 1 green, 2 blue
    typedef level_t [2:0] color_t;

    // Per-pixel record held in RAM
    typedef struct packed {
        logic        lit;
        logic [31:0] blink_stamp;
        logic [31:0] rainbow_stamp;
        color_t      rainbow_color;
        logic [1:0]  falling;
    } pixel_rec_t;

    localparam pixel_rec_t REC_RST = '{
        lit:           1'b0,
        blink_stamp:   32'd0,
        rainbow_stamp: 32'd0,
        rainbow_color: {8'd0, 8'd0, LEVEL_MAX},
        falling:       2'd0
    };

    // Captured command request
    typedef struct packed {
        action_t     action;
        color_t      color;
        logic [15:0] period;
        logic [31:0] now;
    } cmd_t;

    // Update result handed back to the top level
    typedef struct packed {
        logic       fire;
        pixel_rec_t rec;
        color_t     color;
    } upd_t;

endpackage

[src/rgbre_ram.sv]
module rgbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/rgbre_update.sv]
module rgbre_update (
    input  rgbre_pkg::cmd_t     cmd,
    input  rgbre_pkg::pixel_rec_t rec,
    input  logic [15:0]         interval,
    input  logic [7:0]          step,
    output rgbre_pkg::upd_t     upd
);

    logic        blink_due;
    logic        rainbow_due;
    logic [31:0] blink_age;
    logic [31:0] rainbow_age;
    logic [1:0]  fall;
    logic [1:0]  rise;
    logic [7:0]  fall_lvl;
    logic [7:0]  rise_lvl;
    logic [8:0]  rise_sum;
    logic        at_limit;
    logic        do_set;
    logic        do_clear;

    // Wrap-safe elapsed time checks
    assign blink_age   = cmd.now - rec.blink_stamp;
    assign rainbow_age = cmd.now - rec.rainbow_stamp;
    assign blink_due   = !(blink_age < {16'd0, cmd.period});
    assign rainbow_due = rainbow_age > {16'd0, interval};

    // Falling and rising channels of the rainbow
    assign fall     = (rec.falling > rgbre_pkg::CHAN_LAST) ? 2'd0 : rec.falling;
    assign rise     = (fall == rgbre_pkg::CHAN_LAST) ? 2'd0 : fall + 2'd1;
    assign fall_lvl = rec.rainbow_color[fall];
    assign rise_lvl = rec.rainbow_color[rise];
    assign rise_sum = {1'b0, rise_lvl} + {1'b0, step};
    assign at_limit = (fall_lvl <= step) || (rise_sum >= {1'b0, rgbre_pkg::LEVEL_MAX});

    // Blink resolves to set or clear once due
    always_comb
    begin
        do_set   = 1'b0;
        do_clear = 1'b0;
        case (cmd.action)
            rgbre_pkg::ACT_SET:   do_set = 1'b1;
            rgbre_pkg::ACT_CLEAR: do_clear = 1'b1;
            rgbre_pkg::ACT_BLINK:
            begin
                do_set   = blink_due && !rec.lit;
                do_clear = blink_due && rec.lit;
            end
            default: ;
        endcase
    end

    // Record update and emitted color
    always_comb
    begin
        upd.fire  = 1'b0;
        upd.rec   = rec;
        upd.color = '0;
        if (do_set)
        begin
            upd.fire            = 1'b1;
            upd.rec.lit         = 1'b1;
            upd.rec.blink_stamp = cmd.now;
            upd.color           = cmd.color;
        end
        else if (do_clear)
        begin
            upd.fire            = 1'b1;
            upd.rec.lit         = 1'b0;
            upd.rec.blink_stamp = cmd.now;
        end
        else if (cmd.action == rgbre_pkg::ACT_RAINBOW && rainbow_due)
        begin
            upd.fire              = 1'b1;
            upd.rec.rainbow_stamp = cmd.now;
            if (at_limit)
            begin
                upd.rec.rainbow_color[fall] = 8'd0;
                upd.rec.rainbow_color[rise] = rgbre_pkg::LEVEL_MAX;
                upd.rec.falling             = rise;
            end
            else
            begin
                upd.rec.rainbow_color[fall] = fall_lvl - step;
                upd.rec.rainbow_color[rise] = rise_sum[7:0];
            end
            upd.color = upd.rec.rainbow_color;
        end
    end

endmodule

[src/rgb_led_blink_rainbow_engine_top.sv]
// Per-pixel RGB blink / rainbow engine, one record per pixel in a RAM.
// An accepted command reads its pixel record from the RAM; in execute it is
// updated, written back and, if it fires for an in-range pixel, strobed out
// as a result. Busy holds off new commands during execute. Reset: registers
// return to 30 ms / step 20; per-pixel valid bits make every pixel read as
// its reset record at once. Results cannot be stalled.
module rgb_led_blink_rainbow_engine_top #(
    parameter int NUM_PIXELS = rgbre_pkg::NUM_PIXELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [1:0]  led,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [15:0] period_ms,
    input  logic [31:0] now_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  pixel_index,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int REC_W  = $bits(rgbre_pkg::pixel_rec_t);
    localparam logic [ADDR_W+1:0] PIX_COUNT = (ADDR_W + 2)'(NUM_PIXELS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   accept;
    logic                   exec;
    logic [ADDR_W+1:0]      led_wide;
    logic [ADDR_W-1:0]      led_addr;
    logic                   led_ok;

    rgbre_pkg::cmd_t        cmd_reg;
    logic [1:0]             led_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   in_range_reg;
    logic [NUM_PIXELS-1:0]  valid_reg;
    logic [15:0]            interval_reg;
    logic [7:0]             step_reg;

    logic [REC_W-1:0]       ram_rdata;
    rgbre_pkg::pixel_rec_t  rec_cur;
    rgbre_pkg::upd_t        upd;
    logic                   wr_en;

    logic                   result_valid_reg;
    logic [1:0]             pixel_index_reg;
    rgbre_pkg::color_t      color_reg;

    // Request handshake
    assign busy   = (state_reg == ST_EXEC);
    assign exec   = (state_reg == ST_EXEC);
    assign accept = start && !busy;

    assign led_wide = {{ADDR_W{1'b0}}, led};
    assign led_addr = led_wide[ADDR_W-1:0];
    assign led_ok   = led_wide < PIX_COUNT;

    // Control state machine
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.action <= rgbre_pkg::action_t'(action);
            cmd_reg.color  <= {blue, green, red};
            cmd_reg.period <= period_ms;
            cmd_reg.now    <= now_ms;
            led_reg        <= led;
            addr_reg       <= led_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_range_reg <= led_ok;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= rgbre_pkg::INTERVAL_RST;
            step_reg     <= rgbre_pkg::STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbre_pkg::REG_INTERVAL: interval_reg <= cfg_data;
                rgbre_pkg::REG_STEP:     step_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Pixel record RAM
    rgbre_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_PIXELS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr_reg),
        .wdata (upd.rec),
        .re    (accept && led_ok),
        .raddr (led_addr),
        .rdata (ram_rdata)
    );

    // Never-written pixels read as the reset record
    assign rec_cur = valid_reg[addr_reg] ? rgbre_pkg::pixel_rec_t'(ram_rdata)
                                         : rgbre_pkg::REC_RST;

    rgbre_update u_update (
        .cmd      (cmd_reg),
        .rec      (rec_cur),
        .interval (interval_reg),
        .step     (step_reg),
        .upd      (upd)
    );

    assign wr_en = exec && in_range_reg && upd.fire;

    // Per-pixel valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pixel_index_reg <= led_reg;
            color_reg       <= upd.color;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_index  = pixel_index_reg;
    assign out_red      = color_reg[0];
    assign out_green    = color_reg[1];
    assign out_blue     = color_reg[2];

endmodule
